// ===== rtl/core/wfsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfsp_pkg;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VALUE  = 5'b00010,
        PH_LENGTH = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
    localparam logic [2:0] ERR_FIELD_0   = 3'd3;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd4;
    localparam logic [2:0] ERR_GROUP     = 3'd5;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_SGROUP  = 3'd3;
    localparam logic [2:0] WT_EGROUP  = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;
    localparam logic [2:0] WT_BAD6    = 3'd6;
    localparam logic [2:0] WT_BAD7    = 3'd7;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
    localparam int         OUT_DATA_BITS    = 112;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] acc;
        logic [3:0]  count;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [2:0]  error;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_TAG,
        acc:          64'd0,
        count:        4'd0,
        field_number: 32'd0,
        wire_type:    3'd0,
        error:        3'd0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [7:0]  body_byte;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/wire_field_stream_parser.sv =====
// Protobuf wire-format field parser.
// The slave channel takes one byte of an encoded buffer per transaction, with
// tlast on the last byte of the buffer. The master channel gives one result per
// field header, one per fixed or length-delimited body byte, and always one for
// the last byte, which carries the final status code and tlast. tuser gives the
// result kind: field header, body byte, or end status only.
// A byte passes from its transaction into the input register, then through the
// decode logic into the result register on the master side. One byte is taken
// per cycle while results are taken, since the parser state is updated by a
// single pass of logic on each byte.
// When the receiver stalls, the result register holds its transaction and the
// input register holds the next byte; tready falls once both are full.
// Bytes after a detected error produce no result until the end of the buffer.
// Reset empties both registers and returns the parser to waiting for a tag;
// after the last byte of each buffer the parser returns to that state too.
`timescale 1ns / 1ps
`default_nettype none

module wire_field_stream_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // data_byte[7:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // field_number[31:0], wire_type[34:32], value[98:35], body_byte[106:99],
    // error_code[109:107], zero padding[111:110]
    output logic [wfsp_pkg::OUT_DATA_BITS-1:0] m_tdata,
    output logic [1:0]   m_tuser,  // kind[1:0]
    output logic         m_tlast
);
    import wfsp_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    parse_state_t           state_reg;
    parse_state_t           state_next;
    logic [LENGTH_BITS-1:0] remaining_reg;
    logic [LENGTH_BITS-1:0] remaining_next;
    logic                   out_valid_reg;
    result_t                out_result_reg;
    result_t                step_result;
    logic                   step_emit;
    logic                   out_free;
    logic                   proc_fire;

    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    wfsp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .state_q     (state_reg),
        .remaining_q (remaining_reg),
        .data_byte   (in_data_reg),
        .last        (in_last_reg),
        .state_d     (state_next),
        .remaining_d (remaining_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            remaining_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire)
            begin
                state_reg     <= state_next;
                remaining_reg <= remaining_next;
                out_valid_reg <= step_emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && step_emit)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tlast  = out_result_reg.last;
    assign m_tdata  = {2'b00,
                       out_result_reg.error_code,
                       out_result_reg.body_byte,
                       out_result_reg.value,
                       out_result_reg.wire_type,
                       out_result_reg.field_number};

endmodule

`default_nettype wire

// ===== rtl/core/wfsp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfsp_step (
    input  logic [63:0] acc_q,
    input  logic [3:0]  count_q,
    input  logic [6:0]  payload,
    output logic [63:0] acc_d,
    output logic [3:0]  count_d
);
    logic [6:0]  shift;
    logic [63:0] new_bits;

    assign shift    = 7'({3'd0, count_q} * 7'd7);
    assign new_bits = (shift < 7'd64) ? ({57'd0, payload} << shift[5:0]) : 64'd0;
    assign acc_d    = acc_q | new_bits;
    assign count_d  = count_q + 4'd1;

endmodule

`default_nettype wire

// ===== rtl/core/wfsp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfsp_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wfsp_pkg::parse_state_t  state_q,
    input  logic [LENGTH_BITS-1:0]  remaining_q,
    input  logic [7:0]              data_byte,
    input  logic                    last,
    output wfsp_pkg::parse_state_t  state_d,
    output logic [LENGTH_BITS-1:0]  remaining_d,
    output logic                    emit,
    output wfsp_pkg::result_t       result
);
    import wfsp_pkg::*;

    logic [63:0]            varint_v;
    logic [3:0]             count_inc;
    logic [31:0]            tag_fn;
    logic [2:0]             tag_wt;
    logic                   oversize;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   hit;
    logic [2:0]             err;

    wfsp_step u_varint (
        .acc_q   (state_q.acc),
        .count_q (state_q.count),
        .payload (data_byte[6:0]),
        .acc_d   (varint_v),
        .count_d (count_inc)
    );

    assign tag_fn    = varint_v[34:3];
    assign tag_wt    = varint_v[2:0];
    assign oversize  = |(varint_v >> LENGTH_BITS);
    assign rem_dec   = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;

    always_comb
    begin
        state_d     = state_q;
        remaining_d = remaining_q;
        hit         = 1'b0;
        result      = '0;
        err         = ERR_NONE;
        case (state_q.phase)
            PH_TAG, PH_VALUE, PH_LENGTH:
            begin
                state_d.acc   = varint_v;
                state_d.count = count_inc;
                if (data_byte[7])
                begin
                    if (count_inc >= VARINT_MAX_BYTES)
                    begin
                        state_d.error = ERR_TOO_LONG;
                        state_d.phase = PH_ERROR;
                    end
                end
                else
                begin
                    state_d.acc   = 64'd0;
                    state_d.count = 4'd0;
                    if (state_q.phase == PH_TAG)
                    begin
                        if (tag_fn == 32'd0)
                        begin
                            state_d.error = ERR_FIELD_0;
                            state_d.phase = PH_ERROR;
                        end
                        else if (tag_wt inside {WT_BAD6, WT_BAD7})
                        begin
                            state_d.error = ERR_BAD_TYPE;
                            state_d.phase = PH_ERROR;
                        end
                        else if (tag_wt inside {WT_SGROUP, WT_EGROUP})
                        begin
                            state_d.error = ERR_GROUP;
                            state_d.phase = PH_ERROR;
                        end
                        else
                        begin
                            state_d.field_number = tag_fn;
                            state_d.wire_type    = tag_wt;
                            if (tag_wt == WT_VARINT)
                            begin
                                state_d.phase = PH_VALUE;
                            end
                            else if (tag_wt == WT_LEN)
                            begin
                                state_d.phase = PH_LENGTH;
                            end
                            else
                            begin
                                hit                 = 1'b1;
                                result.kind         = KIND_HEADER;
                                result.field_number = tag_fn;
                                result.wire_type    = tag_wt;
                                remaining_d = (tag_wt == WT_FIXED64) ? LENGTH_BITS'(8)
                                                                     : LENGTH_BITS'(4);
                                state_d.phase = PH_BODY;
                            end
                        end
                    end
                    else if (state_q.phase == PH_VALUE)
                    begin
                        hit                 = 1'b1;
                        result.kind         = KIND_HEADER;
                        result.field_number = state_q.field_number;
                        result.wire_type    = state_q.wire_type;
                        result.value        = varint_v;
                        state_d.phase       = PH_TAG;
                    end
                    else if (oversize)
                    begin
                        state_d.error = ERR_TRUNCATED;
                        state_d.phase = PH_ERROR;
                    end
                    else
                    begin
                        hit                 = 1'b1;
                        result.kind         = KIND_HEADER;
                        result.field_number = state_q.field_number;
                        result.wire_type    = state_q.wire_type;
                        result.value        = varint_v;
                        remaining_d         = varint_v[LENGTH_BITS-1:0];
                        state_d.phase       = (varint_v == 64'd0) ? PH_TAG : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                hit                 = 1'b1;
                result.kind         = KIND_BODY;
                result.field_number = state_q.field_number;
                result.wire_type    = state_q.wire_type;
                result.body_byte    = data_byte;
                remaining_d         = rem_dec;
                if (rem_dec == '0)
                begin
                    state_d.phase = PH_TAG;
                end
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            err = state_d.error;
            if (err == ERR_NONE && state_d.phase != PH_TAG)
            begin
                err = ERR_TRUNCATED;
            end
            if (!hit)
            begin
                result      = '0;
                result.kind = KIND_STATUS;
            end
            result.error_code = err;
            result.last       = 1'b1;
            state_d           = STATE_RESET;
            remaining_d       = '0;
        end
    end

    assign emit = hit | last;

endmodule

`default_nettype wire
